[design/sset_pkg.sv]
// Shared types and constants of the sorted set block.
package sset_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int OCNT_W   = 5;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DELETED   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [VAL_W-1:0]  key;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic                     valid;
    logic                     lt;
  } nb_t;

endpackage

[design/sset_if.sv]
// Input and output item channels of the sorted set block.
interface sset_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [sset_pkg::VAL_W-1:0]     value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface sset_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sset_pkg::VAL_W-1:0]     element;
  logic                                  is_last;
  logic                                  list_empty;
  logic [sset_pkg::STAT_W-1:0]           status;
  logic [sset_pkg::OCNT_W-1:0]           count;

  modport source (output valid, element, is_last, list_empty, status, count, input ready);
  modport sink   (input valid, element, is_last, list_empty, status, count, output ready);
endinterface

[design/sset_cell.sv]
// One slot of the sorted chain: holds a value, shifts for insert, delete and listing.
module sset_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sset_pkg::cell_ctrl_t  ctrl_i,
  input  logic signed [sset_pkg::VAL_W-1:0] head_i,
  input  sset_pkg::nb_t         left_i,
  input  sset_pkg::nb_t         right_i,
  output sset_pkg::nb_t         self_o,
  output logic                  eq_o
);

  logic signed [sset_pkg::VAL_W-1:0] value_q, value_d;
  logic                              valid_q, valid_d;
  logic                              lt;

  assign lt   = valid_q && (value_q < ctrl_i.key);
  assign eq_o = valid_q && (value_q == ctrl_i.key);

  assign self_o.value = value_q;
  assign self_o.valid = valid_q;
  assign self_o.lt    = lt;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      sset_pkg::CELL_INS: begin
        if (!lt) begin
          if (left_i.lt) begin
            value_d = ctrl_i.key;
            valid_d = 1'b1;
          end else begin
            value_d = left_i.value;
            valid_d = left_i.valid;
          end
        end
      end
      sset_pkg::CELL_DEL: begin
        if (!lt) begin
          value_d = right_i.value;
          valid_d = right_i.valid;
        end
      end
      sset_pkg::CELL_ROT: begin
        // last occupied slot wraps around to the head value
        if (valid_q && !right_i.valid) value_d = head_i;
        else                           value_d = right_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

[design/sorted_set_insert_delete.sv]
// Top level of the sorted set: op register, cell chain, listing control, output register.
//
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order.
// in_i carries one item (kind 0 insert, 1 delete, value). It is taken only
// while the block is idle. In the cycle after acceptance the operation is applied
// to all cells of the chain at once, using a compare in every cell.
// The block then lists the whole set on out_o, one value per item, in
// ascending order, is_last on the final one; an empty set gives one item
// with list_empty set and element zero. The listing rotates the chain one
// slot per emitted item, so after count items the chain is back in order.
// The first result item is registered in the output register after the ST_OP
// state has updated the chain. A new operation is taken only after its listing
// is complete; the chain rotates one item per cycle while out_o is not stalled.
// A stall on out_o holds the output register and freezes the rotation.
// Reset empties the set (cell valid bits and the count clear) and drops
// any item in flight.
module sorted_set_insert_delete (
  input  logic       clk_i,
  input  logic       rst_ni,
  sset_in_if.sink    in_i,
  sset_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_OP   = 3'b010,
    ST_LIST = 3'b100
  } state_e;

  localparam int N = sset_pkg::CAPACITY;
  localparam int W = sset_pkg::CNT_W;

  state_e                           state_q, state_d;
  logic                             kind_q;
  logic signed [sset_pkg::VAL_W-1:0] key_q;
  logic [W-1:0]                     cnt_q, cnt_d;
  logic [W-1:0]                     idx_q, idx_d;
  sset_pkg::status_e                status_q, status_d;
  sset_pkg::cell_ctrl_t             ctrl;

  sset_pkg::nb_t                    nb [N];
  logic [N-1:0]                     eq;
  logic [N-1:0]                     vld;
  logic                             match;
  logic                             full;
  logic                             load;
  logic                             last;

  logic                             ov_q, ov_d;
  logic signed [sset_pkg::VAL_W-1:0] oel_q, oel_d;
  logic                             olast_q, olast_d;
  logic                             oempty_q, oempty_d;
  sset_pkg::status_e                ostat_q, ostat_d;
  logic [sset_pkg::OCNT_W-1:0]      ocnt_q, ocnt_d;
  logic [W+sset_pkg::OCNT_W-1:0]    cnt_ext;

  localparam sset_pkg::nb_t HEAD_NB = '{value: '0, valid: 1'b1, lt: 1'b1};
  localparam sset_pkg::nb_t TAIL_NB = '{value: '0, valid: 1'b0, lt: 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    sset_pkg::nb_t left_nb, right_nb;
    if (i == 0) begin : g_first
      assign left_nb = HEAD_NB;
    end else begin : g_mid_l
      assign left_nb = nb[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_nb = TAIL_NB;
    end else begin : g_mid_r
      assign right_nb = nb[i+1];
    end
    sset_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .head_i  (nb[0].value),
      .left_i  (left_nb),
      .right_i (right_nb),
      .self_o  (nb[i]),
      .eq_o    (eq[i])
    );
    assign vld[i] = nb[i].valid;
  end

  assign match = |eq;
  assign full  = (cnt_q == W'(N));
  assign load  = !ov_q || out_o.ready;
  assign last  = (idx_q == cnt_q - W'(1));

  assign in_i.ready = (state_q == ST_IDLE);

  assign cnt_ext = {{sset_pkg::OCNT_W{1'b0}}, cnt_q};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    status_d  = status_q;
    ctrl.op   = sset_pkg::CELL_HOLD;
    ctrl.key  = key_q;
    ov_d      = ov_q && !out_o.ready;
    oel_d     = oel_q;
    olast_d   = olast_q;
    oempty_d  = oempty_q;
    ostat_d   = ostat_q;
    ocnt_d    = ocnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_OP;
      end
      ST_OP: begin
        if (!kind_q) begin
          if (match) begin
            status_d = sset_pkg::STAT_DUPLICATE;
          end else if (full) begin
            status_d = sset_pkg::STAT_FULL;
          end else begin
            status_d = sset_pkg::STAT_INSERTED;
            ctrl.op  = sset_pkg::CELL_INS;
            cnt_d    = cnt_q + W'(1);
          end
        end else begin
          if (match) begin
            status_d = sset_pkg::STAT_DELETED;
            ctrl.op  = sset_pkg::CELL_DEL;
            cnt_d    = cnt_q - W'(1);
          end else begin
            status_d = sset_pkg::STAT_NOT_FOUND;
          end
        end
        idx_d   = '0;
        state_d = ST_LIST;
      end
      ST_LIST: begin
        if (load) begin
          ov_d    = 1'b1;
          ostat_d = status_q;
          ocnt_d  = cnt_ext[sset_pkg::OCNT_W-1:0];
          if (cnt_q == '0) begin
            oel_d    = '0;
            olast_d  = 1'b1;
            oempty_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            oel_d    = nb[0].value;
            olast_d  = last;
            oempty_d = 1'b0;
            ctrl.op  = sset_pkg::CELL_ROT;
            idx_d    = idx_q + W'(1);
            if (last) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
      status_q <= sset_pkg::STAT_INSERTED;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      ov_q     <= ov_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      key_q  <= in_i.value;
    end
    oel_q    <= oel_d;
    olast_q  <= olast_d;
    oempty_q <= oempty_d;
    ostat_q  <= ostat_d;
    ocnt_q   <= ocnt_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.element    = oel_q;
  assign out_o.is_last    = olast_q;
  assign out_o.list_empty = oempty_q;
  assign out_o.status     = ostat_q;
  assign out_o.count      = ocnt_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= W'(N))
    else $error("set count above capacity");

  a_chain_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(cnt_q))
    else $error("occupied cells disagree with count");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.list_empty |-> out_o.count == '0 && out_o.is_last)
    else $error("empty listing with nonzero count");

  a_del_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OP && kind_q && match |=> cnt_q == $past(cnt_q) - W'(1))
    else $error("delete did not shrink the set");
`endif

endmodule

[tb/sorted_set_insert_delete_tb.sv]
// Testbench of the sorted set: directed table plus random ops, listings checked against a set model.
module sorted_set_insert_delete_tb;

  localparam logic OP_INSERT    = 1'b0;
  localparam logic OP_DELETE    = 1'b1;
  localparam int   NUM_DIRECTED = 25;
  localparam int   NUM_RANDOM   = 125;
  localparam int   POOL_SIZE    = 24;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [sset_pkg::VAL_W-1:0] element;
    logic                              is_last;
    logic                              list_empty;
    sset_pkg::status_e                 status;
    logic [sset_pkg::OCNT_W-1:0]       count;
  } listing_item_t;

  // typed == 1: status and count below are the expected ones for this row
  typedef struct {
    logic                              kind;
    logic signed [sset_pkg::VAL_W-1:0] value;
    bit                                typed;
    sset_pkg::status_e                 status;
    logic [sset_pkg::OCNT_W-1:0]       count;
  } set_op_row_t;

  logic clk_i;
  logic rst_ni;

  sset_in_if  in_if ();
  sset_out_if out_if ();

  sorted_set_insert_delete i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // set model and the listing items still owed by the block
  logic signed [sset_pkg::VAL_W-1:0] model_set [$];
  listing_item_t                     pending_listing [$];

  logic signed [sset_pkg::VAL_W-1:0] value_pool [POOL_SIZE];
  bit                      burst_mode;
  int                      item_no;
  int                      mismatches;
  int                      results_checked;
  int                      cycle_count;
  int                      n_inserts;
  int                      n_deletes;
  int                      largest_set;
  int                      outcome_seen [5];

  set_op_row_t directed_ops [NUM_DIRECTED] = '{
    '{OP_DELETE, 32'sd5,         1'b1, sset_pkg::STAT_NOT_FOUND, 5'd0},
    '{OP_INSERT, 32'sd0,         1'b1, sset_pkg::STAT_INSERTED,  5'd1},
    '{OP_DELETE, 32'sd0,         1'b1, sset_pkg::STAT_DELETED,   5'd0},
    '{OP_INSERT, 32'sd0,         1'b1, sset_pkg::STAT_INSERTED,  5'd1},
    '{OP_INSERT, 32'sd0,         1'b1, sset_pkg::STAT_DUPLICATE, 5'd1},
    '{OP_INSERT, 32'sh8000_0000, 1'b1, sset_pkg::STAT_INSERTED,  5'd2},
    '{OP_INSERT, 32'sh7FFF_FFFF, 1'b1, sset_pkg::STAT_INSERTED,  5'd3},
    '{OP_INSERT, -32'sd1,        1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd1,         1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd100,       1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, -32'sd100,      1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd2,         1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, -32'sd2,        1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd50,        1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, -32'sd50,       1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd1000,      1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, -32'sd1000,     1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sh5555_5555, 1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'shAAAA_AAAA, 1'b0, sset_pkg::STAT_INSERTED,  5'd0},
    '{OP_INSERT, 32'sd7,         1'b1, sset_pkg::STAT_INSERTED,  5'd16},
    '{OP_INSERT, 32'sd3,         1'b1, sset_pkg::STAT_FULL,      5'd16},
    '{OP_INSERT, 32'sh7FFF_FFFF, 1'b1, sset_pkg::STAT_DUPLICATE, 5'd16},
    '{OP_DELETE, 32'sh8000_0000, 1'b1, sset_pkg::STAT_DELETED,   5'd15},
    '{OP_DELETE, 32'sh7FFF_FFFF, 1'b1, sset_pkg::STAT_DELETED,   5'd14},
    '{OP_DELETE, 32'sd12345,     1'b1, sset_pkg::STAT_NOT_FOUND, 5'd14}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Apply one op to the set model and queue the listing it must produce.
  function automatic void apply_set_op(input logic kind,
                                       input logic signed [sset_pkg::VAL_W-1:0] value,
                                       input bit typed,
                                       input sset_pkg::status_e typed_status,
                                       input logic [sset_pkg::OCNT_W-1:0] typed_count);
    int                pos;
    sset_pkg::status_e outcome;
    listing_item_t     li;
    pos = 0;
    while (pos < model_set.size() && model_set[pos] < value) pos++;
    if (kind == OP_INSERT) begin
      n_inserts++;
      if (pos < model_set.size() && model_set[pos] == value) begin
        outcome = sset_pkg::STAT_DUPLICATE;
      end else if (model_set.size() >= sset_pkg::CAPACITY) begin
        outcome = sset_pkg::STAT_FULL;
      end else begin
        model_set.insert(pos, value);
        outcome = sset_pkg::STAT_INSERTED;
      end
    end else begin
      n_deletes++;
      if (pos < model_set.size() && model_set[pos] == value) begin
        model_set.delete(pos);
        outcome = sset_pkg::STAT_DELETED;
      end else begin
        outcome = sset_pkg::STAT_NOT_FOUND;
      end
    end
    outcome_seen[int'(outcome)]++;
    if (model_set.size() > largest_set) largest_set = model_set.size();

    li.status = typed ? typed_status : outcome;
    li.count  = typed ? typed_count : sset_pkg::OCNT_W'(model_set.size());
    if (model_set.size() == 0) begin
      li.element    = '0;
      li.is_last    = 1'b1;
      li.list_empty = 1'b1;
      pending_listing.push_back(li);
    end else begin
      for (int i = 0; i < model_set.size(); i++) begin
        li.element    = model_set[i];
        li.is_last    = (i == model_set.size() - 1);
        li.list_empty = 1'b0;
        pending_listing.push_back(li);
      end
    end
  endfunction

  // Present one op at the falling edge and hold it until the block takes it.
  task automatic offer_op(input logic kind, input logic signed [sset_pkg::VAL_W-1:0] value,
                          input bit typed, input sset_pkg::status_e st,
                          input logic [sset_pkg::OCNT_W-1:0] cnt);
    int gap;
    burst_mode = (item_no % 40) >= 30;
    item_no++;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.kind  = kind;
    in_if.value = value;
    do @(posedge clk_i); while (!in_if.ready);
    apply_set_op(kind, value, typed, st, cnt);
    @(negedge clk_i);
  endtask

  // output side: random stall per item, check on acceptance
  initial begin
    int            stall;
    listing_item_t exp_item;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      results_checked++;
      if (pending_listing.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: element %0d last %0b empty %0b status %0d count %0d",
                 $time, out_if.element, out_if.is_last, out_if.list_empty, out_if.status,
                 out_if.count);
      end else begin
        exp_item = pending_listing.pop_front();
        if (out_if.element !== exp_item.element || out_if.is_last !== exp_item.is_last ||
            out_if.list_empty !== exp_item.list_empty || out_if.status !== exp_item.status ||
            out_if.count !== exp_item.count) begin
          mismatches++;
          $display("%0t: expected element %0d last %0b empty %0b status %0d count %0d",
                   $time, exp_item.element, exp_item.is_last, exp_item.list_empty,
                   exp_item.status, exp_item.count);
          $display("%0t:   actual element %0d last %0b empty %0b status %0d count %0d",
                   $time, out_if.element, out_if.is_last, out_if.list_empty, out_if.status,
                   out_if.count);
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic                              op_kind;
    logic signed [sset_pkg::VAL_W-1:0] op_value;
    int                                pick;
    in_if.valid = 1'b0;
    in_if.kind  = OP_INSERT;
    in_if.value = '0;
    rst_ni      = 1'b0;

    // small pool so inserts collide, deletes hit and the set fills up
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_ops[i])
      offer_op(directed_ops[i].kind, directed_ops[i].value, directed_ops[i].typed,
               directed_ops[i].status, directed_ops[i].count);

    // alternate fill-heavy and drain-heavy stretches
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ((n / 30) % 2 == 0) op_kind = ($urandom_range(0, 9) < 8) ? OP_INSERT : OP_DELETE;
      else                   op_kind = ($urandom_range(0, 9) < 3) ? OP_INSERT : OP_DELETE;
      pick = $urandom_range(0, 9);
      if (op_kind == OP_DELETE && model_set.size() > 0 && pick < 6)
        op_value = model_set[$urandom_range(0, model_set.size() - 1)];
      else if (pick < 8)
        op_value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        op_value = $urandom;
      offer_op(op_kind, op_value, 1'b0, sset_pkg::STAT_INSERTED, '0);
    end
    in_if.valid = 1'b0;

    while (pending_listing.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d ops (%0d inserts, %0d deletes), %0d listing items checked, largest set %0d",
             n_inserts + n_deletes, n_inserts, n_deletes, results_checked, largest_set);
    $display("outcomes: %0d inserted, %0d duplicate, %0d full, %0d deleted, %0d not found",
             outcome_seen[int'(sset_pkg::STAT_INSERTED)],
             outcome_seen[int'(sset_pkg::STAT_DUPLICATE)],
             outcome_seen[int'(sset_pkg::STAT_FULL)],
             outcome_seen[int'(sset_pkg::STAT_DELETED)],
             outcome_seen[int'(sset_pkg::STAT_NOT_FOUND)]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
